// ----- rtl/core/voice_alloc_filter_envelope_defines.svh -----
// assertion macros for the voice allocator checker
`ifndef VOICE_ALLOC_FILTER_ENVELOPE_DEFINES_SVH
`define VOICE_ALLOC_FILTER_ENVELOPE_DEFINES_SVH

// clocked assertion, quiet while reset is applied
`define VAFE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("vafe check failed");

// clocked assertion that also holds during reset
`define VAFE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("vafe check failed");

`endif

// ----- rtl/core/vafe_pkg.sv -----
// ----------------------------------------------------------------------------
// vafe_pkg
// Shared types and constants of the voice allocator with filter envelopes.
// ----------------------------------------------------------------------------
`default_nettype none

package vafe_pkg;

	localparam int VOICES  = 6;
	localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int VOICE_W = 3;

	localparam logic [16:0] ONE_Q16   = 17'd65536;
	localparam logic [7:0]  FREE_NOTE = 8'd255;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_ATTACK  = 3'd1;
	localparam logic [2:0] PH_DECAY   = 3'd2;
	localparam logic [2:0] PH_SUSTAIN = 3'd3;
	localparam logic [2:0] PH_RELEASE = 3'd4;

	localparam logic [1:0] OP_NOTE_ON  = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	localparam logic [2:0] REG_ATTACK  = 3'd0;
	localparam logic [2:0] REG_DECAY   = 3'd1;
	localparam logic [2:0] REG_SUSTAIN = 3'd2;
	localparam logic [2:0] REG_RELEASE = 3'd3;
	localparam logic [2:0] REG_BASE    = 3'd4;
	localparam logic [2:0] REG_AMOUNT  = 3'd5;

	localparam logic [14:0] CUTOFF_MIN = 15'd500;
	localparam logic [14:0] CUTOFF_MAX = 15'd20000;

	localparam logic       KIND_REPORT = 1'b0;
	localparam logic       KIND_CUTOFF = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [6:0]  note;
		logic [15:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [2:0]  voice;
		logic        note_hit;
		logic        voice_stolen;
		logic [14:0] cutoff_hz;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/voice_alloc_filter_envelope.sv -----
// ----------------------------------------------------------------------------
// voice_alloc_filter_envelope
// Polyphonic voice allocator with a linear ADSR filter envelope per voice.
// ----------------------------------------------------------------------------
// One item is taken at a time. A note on or note off goes to a report state,
// after a scan over every voice when a voice has to be stolen. A tick with
// nonzero elapsed time runs each voice in turn; a voice mid-ramp in attack,
// decay or release goes through one shared 33-step restoring divider, and
// every voice passes two cutoff multiply stages; a stalled result beat holds
// the block up. Ticks with zero elapsed time and operation code 3 are dropped.
`default_nettype none

module voice_alloc_filter_envelope (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire vafe_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output vafe_pkg::out_item_t      out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import vafe_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_REPORT = 4'd2;
	localparam logic [3:0] ST_ADV    = 4'd3;
	localparam logic [3:0] ST_MUL    = 4'd4;
	localparam logic [3:0] ST_DSTART = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_CM1    = 4'd7;
	localparam logic [3:0] ST_CM2    = 4'd8;
	localparam logic [3:0] ST_COUT   = 4'd9;

	// configuration
	logic [15:0] attack_q, decay_q, release_q;
	logic [16:0] sustain_q;
	logic [14:0] base_q;
	logic [17:0] amount_q;

	// voice state
	logic [7:0]  held_q   [VOICES];
	logic [31:0] age_q    [VOICES];
	logic [2:0]  phase_q  [VOICES];
	logic [31:0] pms_q    [VOICES];
	logic [16:0] level_q  [VOICES];
	logic [31:0] age_count_q;

	logic [3:0]        state_q;
	logic [1:0]        op_q;
	logic [6:0]        note_q;
	logic [15:0]       dt_q;
	logic [VIDX_W-1:0] v_q;
	logic [VIDX_W-1:0] best_q;
	logic              hit_q, stolen_q, found_q;
	logic [1:0]        mode_q;
	logic [15:0]       mul_a_q;
	logic [16:0]       mul_b_q;
	logic [15:0]       den_q;
	logic [32:0]       num_s1;
	logic signed [35:0] prod_s1;
	logic signed [49:0] prod_s2;

	logic      out_valid_q;
	out_item_t out_q;
	logic      out_ok;
	logic      out_set;

	div_ctl_t    dstat;
	logic [16:0] quot;

	logic              wr_en;
	logic [VIDX_W-1:0] hit_idx, free_idx;
	logic              hit_any, free_any;
	logic [16:0]       sus;
	logic [32:0]       tsum;
	logic [31:0]       t;
	logic [VIDX_W-1:0] nbest;
	logic signed [15:0] cq;
	logic signed [16:0] hz;
	logic [14:0]       hz_c;
	logic [31:0]       new_age;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign in_stall = (state_q != ST_IDLE);
	assign out_ok   = !out_valid_q || !out_stall;
	assign out_set  = ((state_q == ST_REPORT) || (state_q == ST_COUT)) && out_ok;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sus  = (sustain_q > ONE_Q16) ? ONE_Q16 : sustain_q;
	assign tsum = {1'b0, pms_q[v_q]} + {17'b0, dt_q};
	assign t    = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
	assign nbest = (age_q[v_q] < age_q[best_q]) ? v_q : best_q;
	assign new_age = (age_count_q == 32'hFFFF_FFFF) ? age_count_q : age_count_q + 32'd1;

	// first voice holding the note, first free voice
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		hit_any  = 1'b0;
		free_any = 1'b0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (held_q[i] == {1'b0, in_data.note}) begin
				hit_idx = VIDX_W'(i);
				hit_any = 1'b1;
			end
			if (held_q[i] == FREE_NOTE) begin
				free_idx = VIDX_W'(i);
				free_any = 1'b1;
			end
		end
	end

	// floor of the scaled product, then clamp
	assign cq = prod_s2[47:32];
	assign hz = $signed({2'b00, base_q}) + $signed({cq[15], cq});
	always_comb begin
		priority if (hz < $signed({2'b00, CUTOFF_MIN}))
			hz_c = CUTOFF_MIN;
		else if (hz > $signed({2'b00, CUTOFF_MAX}))
			hz_c = CUTOFF_MAX;
		else
			hz_c = hz[14:0];
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_ATTACK:  prdata = {16'b0, attack_q};
			REG_DECAY:   prdata = {16'b0, decay_q};
			REG_SUSTAIN: prdata = {15'b0, sustain_q};
			REG_RELEASE: prdata = {16'b0, release_q};
			REG_BASE:    prdata = {17'b0, base_q};
			REG_AMOUNT:  prdata = {14'b0, amount_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= 16'd5;
			decay_q   <= 16'd300;
			sustain_q <= 17'd49152;
			release_q <= 16'd300;
			base_q    <= 15'd8000;
			amount_q  <= 18'd32768;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_ATTACK:  attack_q  <= pwdata[15:0];
				REG_DECAY:   decay_q   <= pwdata[15:0];
				REG_SUSTAIN: sustain_q <= pwdata[16:0];
				REG_RELEASE: release_q <= pwdata[15:0];
				REG_BASE:    base_q    <= pwdata[14:0];
				REG_AMOUNT:  amount_q  <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	vafe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DSTART),
		.num    (num_s1),
		.den    (den_q),
		.stat   (dstat),
		.quot   (quot)
	);

	// datapath registers without reset
	always_ff @(posedge clk) begin
		num_s1  <= {16'b0, mul_a_q} * {16'b0, mul_b_q};
		prod_s1 <= $signed(amount_q) * $signed({1'b0, level_q[v_q]});
		prod_s2 <= prod_s1 * $signed(14'sd8000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			age_count_q <= '0;
			op_q        <= '0;
			note_q      <= '0;
			dt_q        <= '0;
			v_q         <= '0;
			best_q      <= '0;
			hit_q       <= 1'b0;
			stolen_q    <= 1'b0;
			found_q     <= 1'b0;
			mode_q      <= '0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			den_q       <= '0;
			for (int i = 0; i < VOICES; i++) begin
				held_q[i]  <= FREE_NOTE;
				age_q[i]   <= '0;
				phase_q[i] <= PH_IDLE;
				pms_q[i]   <= '0;
				level_q[i] <= '0;
			end
		end else begin
			if (out_set)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q     <= in_data.operation;
						note_q   <= in_data.note;
						dt_q     <= in_data.elapsed_ms;
						stolen_q <= 1'b0;
						if (in_data.operation == OP_NOTE_ON) begin
							hit_q   <= hit_any;
							found_q <= 1'b1;
							if (hit_any) begin
								v_q     <= hit_idx;
								state_q <= ST_REPORT;
							end else if (free_any) begin
								v_q     <= free_idx;
								state_q <= ST_REPORT;
							end else begin
								v_q      <= '0;
								best_q   <= '0;
								stolen_q <= 1'b1;
								state_q  <= ST_SCAN;
							end
						end else if (in_data.operation == OP_NOTE_OFF) begin
							hit_q   <= hit_any;
							found_q <= hit_any;
							v_q     <= hit_any ? hit_idx : '0;
							state_q <= ST_REPORT;
						end else if (in_data.operation == OP_TICK &&
							in_data.elapsed_ms != 16'd0) begin
							v_q     <= '0;
							state_q <= ST_ADV;
						end
					end
				end
				ST_SCAN: begin
					// oldest age wins, lowest index on a tie
					if (v_q == VIDX_W'(VOICES - 1)) begin
						v_q     <= nbest;
						state_q <= ST_REPORT;
					end else begin
						best_q <= nbest;
						v_q    <= v_q + VIDX_W'(1);
					end
				end
				ST_REPORT: begin
					if (out_ok) begin
						if (op_q == OP_NOTE_ON) begin
							phase_q[v_q] <= PH_ATTACK;
							pms_q[v_q]   <= '0;
							level_q[v_q] <= '0;
							held_q[v_q]  <= {1'b0, note_q};
							age_count_q  <= new_age;
							age_q[v_q]   <= new_age;
						end else if (found_q) begin
							phase_q[v_q] <= PH_RELEASE;
							pms_q[v_q]   <= '0;
							held_q[v_q]  <= FREE_NOTE;
						end
						out_q.result_kind  <= KIND_REPORT;
						out_q.voice        <= VOICE_W'(v_q);
						out_q.note_hit     <= hit_q;
						out_q.voice_stolen <= stolen_q;
						out_q.cutoff_hz    <= '0;
						out_q.last         <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				ST_ADV: begin
					mode_q <= phase_q[v_q][1:0];
					unique case (phase_q[v_q])
						PH_ATTACK: begin
							if (attack_q == 16'd0 || t >= {16'b0, attack_q}) begin
								level_q[v_q] <= ONE_Q16;
								phase_q[v_q] <= PH_DECAY;
								pms_q[v_q]   <= '0;
								state_q      <= ST_CM1;
							end else begin
								pms_q[v_q] <= t;
								mul_a_q    <= t[15:0];
								mul_b_q    <= ONE_Q16;
								den_q      <= attack_q;
								state_q    <= ST_MUL;
							end
						end
						PH_DECAY: begin
							pms_q[v_q] <= t;
							if (decay_q == 16'd0 || t >= {16'b0, decay_q}) begin
								level_q[v_q] <= sus;
								phase_q[v_q] <= PH_SUSTAIN;
								state_q      <= ST_CM1;
							end else begin
								mul_a_q <= t[15:0];
								mul_b_q <= ONE_Q16 - sus;
								den_q   <= decay_q;
								state_q <= ST_MUL;
							end
						end
						PH_SUSTAIN: begin
							pms_q[v_q]   <= t;
							level_q[v_q] <= sus;
							state_q      <= ST_CM1;
						end
						PH_RELEASE: begin
							pms_q[v_q] <= t;
							if (release_q == 16'd0 || t >= {16'b0, release_q}) begin
								level_q[v_q] <= '0;
								phase_q[v_q] <= PH_IDLE;
								state_q      <= ST_CM1;
							end else begin
								mul_a_q <= release_q - t[15:0];
								mul_b_q <= sus;
								den_q   <= release_q;
								state_q <= ST_MUL;
							end
						end
						default: begin
							pms_q[v_q]   <= t;
							level_q[v_q] <= '0;
							state_q      <= ST_CM1;
						end
					endcase
				end
				ST_MUL:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (dstat.done) begin
						// decay counts down from one, the others take the quotient
						if (mode_q == PH_DECAY[1:0])
							level_q[v_q] <= ONE_Q16 - quot;
						else
							level_q[v_q] <= quot;
						state_q <= ST_CM1;
					end
				end
				ST_CM1: state_q <= ST_CM2;
				ST_CM2: state_q <= ST_COUT;
				ST_COUT: begin
					if (out_ok) begin
						out_q.result_kind  <= KIND_CUTOFF;
						out_q.voice        <= VOICE_W'(v_q);
						out_q.note_hit     <= 1'b0;
						out_q.voice_stolen <= 1'b0;
						out_q.cutoff_hz    <= hz_c;
						out_q.last         <= (v_q == VIDX_W'(VOICES - 1));
						if (v_q == VIDX_W'(VOICES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							v_q     <= v_q + VIDX_W'(1);
							state_q <= ST_ADV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/vafe_div.sv -----
// ----------------------------------------------------------------------------
// vafe_div
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vafe_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [32:0]          num,
	input  wire logic [15:0]          den,
	output vafe_pkg::div_ctl_t        stat,
	output logic [16:0]               quot
);
	import vafe_pkg::*;

	logic [32:0] q_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] sh;
	logic        fit;

	assign sh  = {rem_q, q_q[32]};
	assign fit = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[31:0], fit};
			rem_q <= fit ? 16'(sh - {1'b0, den_q}) : sh[15:0];
		end
	end

	assign stat.start = busy_q;
	assign stat.done  = done_q;
	assign quot       = q_q[16:0];

endmodule

`default_nettype wire

// ----- rtl/core/vafe_check.sv -----
// ----------------------------------------------------------------------------
// vafe_check
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voice_alloc_filter_envelope_defines.svh"

module vafe_check (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire vafe_pkg::out_item_t  out_data
);
	import vafe_pkg::*;

	// a stalled beat holds
	`VAFE_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
	// reports are single beats with no cutoff
	`VAFE_ASSERT(a_report, out_valid && out_data.result_kind == KIND_REPORT |-> out_data.last && out_data.cutoff_hz == 15'd0)
	// cutoff beats stay within the clamp
	`VAFE_ASSERT(a_clamp, out_valid && out_data.result_kind == KIND_CUTOFF |-> out_data.cutoff_hz >= CUTOFF_MIN && out_data.cutoff_hz <= CUTOFF_MAX)
	// last cutoff beat belongs to the top voice
	`VAFE_ASSERT(a_last, out_valid && out_data.result_kind == KIND_CUTOFF && out_data.last |-> out_data.voice == VOICE_W'(VOICES - 1))
	// no beat shown during reset
	`VAFE_ASSERT_ALWAYS(a_rst, !arst_n |-> !out_valid)

endmodule

bind voice_alloc_filter_envelope vafe_check u_vafe_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
